[hw/rtl/lmd_pkg.sv]
`default_nettype none

package lmd_pkg;

	localparam int unsigned HDR_BYTES = 4;
	localparam int unsigned OPC_W     = 6;
	localparam int unsigned POS_W     = 9;

	// result kinds
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_CREDIT = 2'd1;
	localparam logic [1:0] KIND_BADOPC = 2'd2;

	// configuration register indexes
	localparam logic [0:0] CFG_DATA_OPC   = 1'b0;
	localparam logic [0:0] CFG_CREDIT_OPC = 1'b1;

	localparam logic [OPC_W-1:0] DATA_OPC_RST   = 6'd0;
	localparam logic [OPC_W-1:0] CREDIT_OPC_RST = 6'd1;

	typedef struct packed {
		logic [OPC_W-1:0] data_opc;
		logic [OPC_W-1:0] credit_opc;
	} lmd_cfg_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       node;
		logic [7:0]       payload_byte;
		logic             byte_valid;
		logic             last;
		logic [15:0]      credit_amount;
		logic             underflow;
		logic [OPC_W-1:0] bad_opcode;
	} lmd_result_t;

endpackage

`default_nettype wire

[hw/rtl/lmd_parser.sv]
`default_nettype none

// Per-byte message parser: header capture, padding count, result build.
module lmd_parser import lmd_pkg::*; #(
	parameter int unsigned BEAT_BYTES = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  rx_byte,
	input  wire lmd_cfg_t    cfg,
	output logic             res_valid,
	output lmd_result_t      res
);

	localparam int unsigned BCW = (BEAT_BYTES > 1) ? $clog2(BEAT_BYTES) : 1;
	localparam logic [BCW-1:0] BC_LAST = BCW'(BEAT_BYTES - 1);

	logic [POS_W-1:0] pos_q;
	logic [BCW-1:0]   bc_q;
	logic [7:0]       src_q;
	logic [7:0]       len_q;
	logic [OPC_W-1:0] opc_q;
	logic [7:0]       clo_q;
	logic [7:0]       chi_q;
	logic [7:0]       flg_q;

	logic             is_hdr;
	logic             at_opc;
	logic [OPC_W-1:0] opc_eff;
	logic             is_data;
	logic             is_credit;
	logic [POS_W:0]   pos_nx;
	logic [POS_W:0]   body_end;
	logic             reach;
	logic             final_byte;
	logic             data_win;
	logic             empty_msg;
	logic             cap_lo;
	logic             cap_hi;
	logic             cap_flg;
	logic [7:0]       clo_eff;
	logic [7:0]       chi_eff;
	logic [7:0]       flg_eff;

	always_comb begin
		is_hdr     = (pos_q < POS_W'(3));
		at_opc     = (pos_q == POS_W'(3));
		opc_eff    = at_opc ? rx_byte[7:2] : opc_q;
		is_data    = (opc_eff == cfg.data_opc);
		is_credit  = !is_data && (opc_eff == cfg.credit_opc);
		pos_nx     = {1'b0, pos_q} + 1'b1;
		body_end   = (POS_W+1)'(HDR_BYTES) + {{(POS_W-7){1'b0}}, len_q};
		reach      = (pos_nx >= body_end);
		// message end: header+payload covered and beat boundary reached
		final_byte = !is_hdr && reach && (bc_q == BC_LAST);
		data_win   = (pos_q >= POS_W'(HDR_BYTES)) && ({1'b0, pos_q} < body_end);
		empty_msg  = at_opc && (len_q == 8'd0);
		cap_lo     = is_credit && (pos_q == POS_W'(4));
		cap_hi     = is_credit && (pos_q == POS_W'(5));
		cap_flg    = is_credit && (pos_q == POS_W'(7));
		clo_eff    = cap_lo  ? rx_byte : clo_q;
		chi_eff    = cap_hi  ? rx_byte : chi_q;
		flg_eff    = cap_flg ? rx_byte : flg_q;
	end

	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		if (!is_hdr) begin
			if (is_data) begin
				if (empty_msg || data_win) begin
					res_valid        = 1'b1;
					res.kind         = KIND_DATA;
					res.node         = src_q;
					res.payload_byte = data_win ? rx_byte : 8'd0;
					res.byte_valid   = data_win;
					res.last         = empty_msg || (pos_nx == body_end);
				end
			end else if (final_byte) begin
				res_valid = 1'b1;
				res.node  = src_q;
				res.last  = 1'b1;
				if (is_credit) begin
					res.kind          = KIND_CREDIT;
					res.credit_amount = {chi_eff, clo_eff};
					res.underflow     = flg_eff[7];
				end else begin
					res.kind       = KIND_BADOPC;
					res.bad_opcode = opc_eff;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			bc_q  <= '0;
			src_q <= '0;
			len_q <= '0;
			opc_q <= '0;
			clo_q <= '0;
			chi_q <= '0;
			flg_q <= '0;
		end else if (step) begin
			pos_q <= final_byte ? '0 : pos_nx[POS_W-1:0];
			bc_q  <= (bc_q == BC_LAST) ? '0 : bc_q + 1'b1;
			if (pos_q == '0) begin
				clo_q <= '0;
				chi_q <= '0;
				flg_q <= '0;
			end
			if (pos_q == POS_W'(1)) begin
				src_q <= rx_byte;
			end
			if (pos_q == POS_W'(2)) begin
				len_q <= rx_byte;
			end
			if (at_opc) begin
				opc_q <= rx_byte[7:2];
			end
			if (cap_lo) begin
				clo_q <= rx_byte;
			end
			if (cap_hi) begin
				chi_q <= rx_byte;
			end
			if (cap_flg) begin
				flg_q <= rx_byte;
			end
		end
	end

	// position and beat counter restart together at every message start
	a_bc_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == '0) |-> (bc_q == '0))
		else $error("beat counter out of step with message position");

	// a message never runs past its longest padded size
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < POS_W'(HDR_BYTES + 255 + BEAT_BYTES))
		else $error("message position past end of longest message");

endmodule

`default_nettype wire

[hw/rtl/link_message_deframer_core.sv]
`default_nettype none

// Channel   | handshake           | payload
// ----------+---------------------+---------------------------------------------
// input     | in_valid / in_stall | rx_byte
// output    | out_valid/out_stall | kind node payload_byte byte_valid last
//           |                     | credit_amount underflow bad_opcode
// config    | cfg_we              | cfg_index cfg_data
//
// One byte per cycle sustained while the sink does not stall. A request is held in the
// input register, is parsed by the single-pass logic in lmd_parser and, when it
// yields a result, lands in the output register.
// Reset clears the parser to "awaiting header" and the opcodes to 0 and 1.
// in_stall rises only while the input register is full and the output
// register holds a result that the sink is stalling.
module link_message_deframer_core import lmd_pkg::*; #(
	parameter int unsigned BEAT_BYTES = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// byte stream in
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       rx_byte,
	// results out
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [1:0]            kind,
	output logic [7:0]            node,
	output logic [7:0]            payload_byte,
	output logic                  byte_valid,
	output logic                  last,
	output logic [15:0]           credit_amount,
	output logic                  underflow,
	output logic [OPC_W-1:0]      bad_opcode,
	// configuration
	input  wire logic             cfg_we,
	input  wire logic [0:0]       cfg_index,
	input  wire logic [OPC_W-1:0] cfg_data
);

	logic [OPC_W-1:0] data_opc_q;
	logic [OPC_W-1:0] credit_opc_q;
	lmd_cfg_t         cfg;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             valid_s2;
	lmd_result_t      res_s2;

	logic             in_take;
	logic             advance;
	logic             res_valid;
	lmd_result_t      res;

	// config registers, to be written only while idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_opc_q   <= DATA_OPC_RST;
			credit_opc_q <= CREDIT_OPC_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DATA_OPC:   data_opc_q   <= cfg_data;
				CFG_CREDIT_OPC: credit_opc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.data_opc   = data_opc_q;
	assign cfg.credit_opc = credit_opc_q;

	// parse moves the input register on whenever the output slot is free
	// or being drained this cycle
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
		end
	end

	lmd_parser #(
		.BEAT_BYTES (BEAT_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (byte_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register; a byte that yields no parser result leaves it empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign kind          = res_s2.kind;
	assign node          = res_s2.node;
	assign payload_byte  = res_s2.payload_byte;
	assign byte_valid    = res_s2.byte_valid;
	assign last          = res_s2.last;
	assign credit_amount = res_s2.credit_amount;
	assign underflow     = res_s2.underflow;
	assign bad_opcode    = res_s2.bad_opcode;

	// stall back to the source only with both registers full and sink stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a blocked result");

	// a stalled result is never overwritten by the parser
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |-> !advance)
		else $error("parser advanced over a stalled result");

	// credit and bad-opcode results always close their message
	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (res_s2.kind == KIND_CREDIT || res_s2.kind == KIND_BADOPC))
		|-> (res_s2.last && !res_s2.byte_valid))
		else $error("report result without last or with a data byte");

	// only the three defined kinds reach the output
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.kind == KIND_DATA || res_s2.kind == KIND_CREDIT ||
			res_s2.kind == KIND_BADOPC))
		else $error("undefined result kind");

endmodule

`default_nettype wire
